### rtl/dmif_pkg.sv
`timescale 1ns / 1ps
package dmif_pkg;

  // Cache and memory geometry
  localparam int CACHE_LINES  = 4;
  localparam int MEMORY_WORDS = 1024;
  localparam int BLOCK_WORDS  = 16;
  localparam int INSTR_WORDS  = 4;
  localparam int BLOCK_COUNT  = MEMORY_WORDS / BLOCK_WORDS;

  localparam int WORD_W   = 32;
  localparam int PC_W     = 13;
  localparam int BASE_W   = 12;
  localparam int MEM_AW   = $clog2(MEMORY_WORDS);
  localparam int LINE_W   = $clog2(CACHE_LINES);
  localparam int TAG_W    = $clog2(BLOCK_COUNT);
  localparam int BW_W     = $clog2(BLOCK_WORDS);
  localparam int IW_W     = $clog2(INSTR_WORDS);
  localparam int BANK_AW  = LINE_W + BW_W - IW_W;
  localparam int FCNT_W   = $clog2(BLOCK_WORDS + 1);
  localparam int BLK_SH   = 4;

  localparam logic [BASE_W-1:0] CODE_BASE_RESET = 12'd384;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [9:0]               mem_index;
    logic signed [WORD_W-1:0] mem_value;
    logic [PC_W-1:0]          fetch_pc;
  } req_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] instr_word0;
    logic signed [WORD_W-1:0] instr_word1;
    logic signed [WORD_W-1:0] instr_word2;
    logic signed [WORD_W-1:0] instr_word3;
    logic                     hit;
    logic                     fault;
  } rsp_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic check;
    logic fill;
    logic read;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fetch_req;
    logic fault;
    logic hit;
    logic fill_done;
  } dp_status_t;

endpackage

### rtl/dmif_ctrl.sv
`timescale 1ns / 1ps
module dmif_ctrl
  import dmif_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_FILL  = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one word at a time
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = status.fetch_req ? S_CHECK : S_RESP;
        end
      end
      S_CHECK: begin
        if (status.fault) begin
          state_next = S_RESP;
        end else if (status.hit) begin
          state_next = S_READ;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (status.fill_done) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive commands from the current state
  always_comb begin
    cmd.load  = (state == S_IDLE) && start;
    cmd.check = (state == S_CHECK);
    cmd.fill  = (state == S_FILL);
    cmd.read  = (state == S_READ);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

### rtl/dmif_datapath.sv
`timescale 1ns / 1ps
module dmif_datapath
  import dmif_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  req_word_t         request,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output rsp_word_t         result
);

  logic [BASE_W-1:0] code_base;

  logic            op_q;
  logic [PC_W-1:0] pc_q;
  logic            fault_q;
  logic            hit_q;
  logic [LINE_W-1:0] line_q;
  logic [TAG_W-1:0]  tag_q;
  logic [IW_W-1:0]   word_q;

  logic [PC_W-1:0]   offset;
  logic              below;
  logic              beyond;
  logic [LINE_W-1:0] line_now;
  logic [TAG_W-1:0]  tag_now;

  logic [CACHE_LINES-1:0] line_valid;
  logic [TAG_W-1:0]       line_tag [CACHE_LINES];

  logic [WORD_W-1:0] instr_mem [MEMORY_WORDS];
  logic [WORD_W-1:0] mem_rdata;
  logic [MEM_AW-1:0] mem_raddr;

  logic [FCNT_W-1:0] fill_cnt;
  logic              fill_issue;
  logic              fill_wr_valid;
  logic [BW_W-1:0]   fill_wr_idx;

  logic [INSTR_WORDS-1:0][WORD_W-1:0] rd_words;
  logic                               show_words;

  // Hold the base register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_base <= CODE_BASE_RESET;
    end else if (cfg_we) begin
      code_base <= cfg_wdata;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= request.op;
      pc_q <= request.fetch_pc;
    end
  end

  // Work out block, line and fault from the offset
  always_comb begin
    below    = pc_q < {1'b0, code_base};
    offset   = pc_q - {1'b0, code_base};
    beyond   = offset[PC_W-1:BLK_SH] >= (PC_W - BLK_SH)'(BLOCK_COUNT);
    line_now = offset[BLK_SH +: LINE_W];
    tag_now  = offset[BLK_SH +: TAG_W];
  end

  assign status.fetch_req = (request.op == OP_FETCH);
  assign status.fault     = below | beyond;
  assign status.hit       = line_valid[line_now] && (line_tag[line_now] == tag_now);
  assign status.fill_done = fill_wr_valid && (fill_wr_idx == BW_W'(BLOCK_WORDS - 1));

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fault_q <= status.fault;
      hit_q   <= status.hit;
      line_q  <= line_now;
      tag_q   <= tag_now;
      word_q  <= offset[2 +: IW_W];
    end
  end

  // Step through the block during a fill
  assign fill_issue = cmd.fill && (fill_cnt < FCNT_W'(BLOCK_WORDS));
  assign mem_raddr  = {tag_q, fill_cnt[BW_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt      <= '0;
      fill_wr_valid <= 1'b0;
    end else begin
      if (cmd.check) begin
        fill_cnt <= '0;
      end else if (fill_issue) begin
        fill_cnt <= fill_cnt + FCNT_W'(1);
      end
      fill_wr_valid <= fill_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_issue) begin
      fill_wr_idx <= fill_cnt[BW_W-1:0];
    end
  end

  // Backing memory: write on load, read during fill
  always_ff @(posedge clk) begin
    if (cmd.load && (request.op == OP_LOAD)) begin
      instr_mem[request.mem_index] <= request.mem_value;
    end
    if (fill_issue) begin
      mem_rdata <= instr_mem[mem_raddr];
    end
  end

  // Mark the line valid once its last word lands
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (status.fill_done) begin
      line_valid[line_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_LINES; i++) begin
        line_tag[i] <= '0;
      end
    end else if (status.fill_done) begin
      line_tag[line_q] <= tag_q;
    end
  end

  // One bank per word of an instruction, all read in the same cycle
  for (genvar b = 0; b < INSTR_WORDS; b++) begin : g_bank
    logic [WORD_W-1:0] bank_mem [CACHE_LINES * BLOCK_WORDS / INSTR_WORDS];
    logic [WORD_W-1:0] bank_rdata;

    always_ff @(posedge clk) begin
      if (fill_wr_valid && (fill_wr_idx[IW_W-1:0] == IW_W'(b))) begin
        bank_mem[{line_q, fill_wr_idx[BW_W-1:IW_W]}] <= mem_rdata;
      end
      if (cmd.read) begin
        bank_rdata <= bank_mem[BANK_AW'({line_q, word_q})];
      end
    end

    assign rd_words[b] = bank_rdata;
  end

  // Drop the words for loads and faults
  assign show_words = (op_q == OP_FETCH) && !fault_q;

  always_comb begin
    result.instr_word0 = show_words ? rd_words[0] : '0;
    result.instr_word1 = show_words ? rd_words[1] : '0;
    result.instr_word2 = show_words ? rd_words[2] : '0;
    result.instr_word3 = show_words ? rd_words[3] : '0;
    result.hit         = show_words && hit_q;
    result.fault       = (op_q == OP_FETCH) && fault_q;
  end

endmodule

### rtl/direct_mapped_instruction_fetch_top.sv
`timescale 1ns / 1ps
// States from start to done: load IDLE, RESP; fault IDLE, CHECK, RESP; a hit adds
// READ; a miss FILL, READ, where FILL reads 16 words over the single read port.
// The next word is taken in the cycle after done, so throughput equals latency.
// done pulses for one cycle; the receiver cannot stall it.
// Reset clears the controller, the line valid bits and sets code_base to 384;
// instruction memory and cached words are undefined until written.
module direct_mapped_instruction_fetch_top
  import dmif_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_word_t         request,
  output logic              done,
  output rsp_word_t         result,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dmif_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dmif_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

### test/fetch_checker.sv
`timescale 1ns / 1ps
module fetch_checker
  import dmif_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  req_word_t         request,
  input  logic              done,
  input  rsp_word_t         result,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  output int                pending,
  output int                errors,
  output int                hits_seen,
  output int                faults_seen
);

  localparam int BLOCK_BYTES = 16;

  // Shadow copies of the memory, the cached lines and the base register
  logic [WORD_W-1:0] mem_shadow   [MEMORY_WORDS];
  logic [WORD_W-1:0] line_shadow  [CACHE_LINES*BLOCK_WORDS];
  int                tag_shadow   [CACHE_LINES];
  bit                valid_shadow [CACHE_LINES];
  logic [BASE_W-1:0] base_shadow;
  rsp_word_t         awaited_words [$];

  // Apply one accepted word to the shadow state and return the word it must produce
  function automatic rsp_word_t fetch_outcome(input req_word_t w);
    rsp_word_t r;
    int        offs;
    int        blk;
    int        ln;
    int        sel;
    bit        found;
    r = '0;
    if (w.op == OP_LOAD) begin
      mem_shadow[w.mem_index] = w.mem_value;
      return r;
    end
    offs = int'(w.fetch_pc) - int'(base_shadow);
    blk  = offs / BLOCK_BYTES;
    // Below the base or past the end of memory: fault, cache left alone
    if (offs < 0 || blk >= BLOCK_COUNT) begin
      r.fault = 1'b1;
      return r;
    end
    ln    = blk % CACHE_LINES;
    sel   = ln * BLOCK_WORDS + ((offs >> 2) & 3) * INSTR_WORDS;
    found = valid_shadow[ln] && tag_shadow[ln] == blk;
    // On a miss pull the whole block in and retag the line
    if (!found) begin
      for (int k = 0; k < BLOCK_WORDS; k++)
        line_shadow[ln*BLOCK_WORDS + k] = mem_shadow[blk*BLOCK_WORDS + k];
      tag_shadow[ln]   = blk;
      valid_shadow[ln] = 1'b1;
    end
    r.instr_word0 = line_shadow[sel];
    r.instr_word1 = line_shadow[sel + 1];
    r.instr_word2 = line_shadow[sel + 2];
    r.instr_word3 = line_shadow[sel + 3];
    r.hit         = found;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Track config writes, retire results, predict accepted words
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      base_shadow = CODE_BASE_RESET;
      for (int i = 0; i < CACHE_LINES; i++) begin
        valid_shadow[i] = 1'b0;
        tag_shadow[i]   = 0;
      end
      awaited_words.delete();
      pending <= 0;
    end else begin
      if (cfg_we)
        base_shadow = cfg_wdata;
      if (done) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result word with nothing awaited, expected none, got %h",
                   $time, result);
          errors++;
        end else begin
          want = awaited_words.pop_front();
          check_field("instr_word0", want.instr_word0, result.instr_word0);
          check_field("instr_word1", want.instr_word1, result.instr_word1);
          check_field("instr_word2", want.instr_word2, result.instr_word2);
          check_field("instr_word3", want.instr_word3, result.instr_word3);
          check_field("hit", WORD_W'(want.hit), WORD_W'(result.hit));
          check_field("fault", WORD_W'(want.fault), WORD_W'(result.fault));
          if (result.hit === 1'b1)
            hits_seen++;
          if (result.fault === 1'b1)
            faults_seen++;
        end
      end
      if (start && !busy)
        awaited_words.push_back(fetch_outcome(request));
      pending <= awaited_words.size();
    end
  end

endmodule

### test/tb_direct_mapped_instruction_fetch_top.sv
`timescale 1ns / 1ps
module tb_direct_mapped_instruction_fetch_top;
  import dmif_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 113;
  localparam int BLOCK_BYTES = 16;
  localparam int PC_MAX      = (1 << PC_W) - 1;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  req_word_t         request;
  logic              done;
  rsp_word_t         result;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;

  int pending;
  int errors;
  int hits_seen;
  int faults_seen;

  // Which memory words and whole blocks are safe to fetch from
  bit                written  [MEMORY_WORDS];
  bit                blk_full [BLOCK_COUNT];
  int                full_blks [$];
  int                last_blk;
  int                gap_pct;
  int                n_loads;
  int                n_fetches;
  int                n_bases;
  logic [BASE_W-1:0] base_now;
  req_word_t         plan [$];

  direct_mapped_instruction_fetch_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fetch_checker fetch_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .errors      (errors),
    .hits_seen   (hits_seen),
    .faults_seen (faults_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_direct_mapped_instruction_fetch_top failed");
    $finish;
  end

  function automatic req_word_t load_word(input int idx, input logic [WORD_W-1:0] val);
    req_word_t w;
    w.op        = OP_LOAD;
    w.mem_index = 10'(idx);
    w.mem_value = val;
    w.fetch_pc  = PC_W'($urandom());
    return w;
  endfunction

  function automatic req_word_t fetch_word(input int pc);
    req_word_t w;
    w.op        = OP_FETCH;
    w.mem_index = 10'($urandom());
    w.mem_value = $urandom();
    w.fetch_pc  = PC_W'(pc);
    return w;
  endfunction

  // Pick an address either under the base or past the end of memory
  function automatic int fault_pc();
    if (base_now != 0 && $urandom_range(0, 1) == 0)
      return $urandom_range(0, int'(base_now) - 1);
    return $urandom_range(int'(base_now) + BLOCK_COUNT*BLOCK_BYTES, PC_MAX);
  endfunction

  // Hold the word until the block takes it, then note what memory now holds
  task automatic issue(input req_word_t w);
    int blk;
    bit all_set;
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    if (w.op == OP_LOAD) begin
      n_loads++;
      written[w.mem_index] = 1'b1;
      blk     = w.mem_index / BLOCK_WORDS;
      all_set = 1'b1;
      for (int k = 0; k < BLOCK_WORDS; k++)
        all_set &= written[blk*BLOCK_WORDS + k];
      if (all_set && !blk_full[blk]) begin
        blk_full[blk] = 1'b1;
        full_blks.push_back(blk);
      end
    end else begin
      n_fetches++;
    end
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and hold until every awaited word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [BASE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_now = value;
    n_bases++;
  endtask

  // Queue the next sequence: a block fill, a stray load, a faulting or a real fetch
  task automatic plan_next();
    int roll;
    int blk;
    roll = $urandom_range(0, 99);
    if (full_blks.size() == 0 || roll < 8) begin
      blk = $urandom_range(0, BLOCK_COUNT - 1);
      for (int k = 0; k < BLOCK_WORDS; k++)
        plan.push_back(load_word(blk*BLOCK_WORDS + k, $urandom()));
    end else if (roll < 20) begin
      plan.push_back(load_word($urandom_range(0, MEMORY_WORDS - 1), $urandom()));
    end else if (roll < 30) begin
      plan.push_back(fetch_word(fault_pc()));
    end else begin
      // Revisit the last block often so that hits come up
      if (roll >= 60 || last_blk < 0)
        last_blk = full_blks[$urandom_range(0, full_blks.size() - 1)];
      plan.push_back(fetch_word(int'(base_now) + last_blk*BLOCK_BYTES +
                                $urandom_range(0, BLOCK_BYTES - 1)));
    end
  endtask

  initial begin
    logic [BASE_W-1:0] bases [PHASES];
    logic [WORD_W-1:0] v;
    int                n;
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    last_blk  = -1;
    gap_pct   = 0;
    base_now  = CODE_BASE_RESET;
    bases[0]  = '0;
    bases[1]  = '1;
    bases[2]  = BASE_W'($urandom_range(1, (1 << BASE_W) - 2));
    bases[3]  = CODE_BASE_RESET;
    bases[4]  = BASE_W'($urandom());
    bases[5]  = BASE_W'($urandom());
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill block 0 with corner values, then probe it under the reset base
    for (int k = 0; k < BLOCK_WORDS; k++) begin
      case (k)
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = '0;
        3: v = '1;
        default: v = $urandom();
      endcase
      issue(load_word(k, v));
    end
    last_blk = 0;
    issue(fetch_word(int'(CODE_BASE_RESET)));
    issue(fetch_word(int'(CODE_BASE_RESET) + BLOCK_BYTES - 1));
    issue(fetch_word(int'(CODE_BASE_RESET) - 1));
    issue(fetch_word(int'(CODE_BASE_RESET) + BLOCK_COUNT*BLOCK_BYTES));
    issue(fetch_word(PC_MAX));
    issue(fetch_word(0));
    // A load to a cached block must not show until the line is refilled
    issue(load_word(0, $urandom()));
    issue(fetch_word(int'(CODE_BASE_RESET) + 2));
    issue(load_word(MEMORY_WORDS - 1, $urandom()));

    // Random phases, one per base setting; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_base(bases[p]);
      n = 0;
      while (n < PHASE_WORDS || plan.size() != 0) begin
        if (plan.size() == 0)
          plan_next();
        if (n % 32 == 0)
          gap_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 3) * 15;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
          pause($urandom_range(1, 11));
        issue(plan.pop_front());
        n++;
        if (p == 2 && n == 60)
          drain();
      end
    end

    drain();
    repeat (25) @(posedge clk);
    $display("Run covered %0d loads and %0d fetches over %0d code_base settings,",
             n_loads, n_fetches, n_bases);
    $display("with %0d cache hits and %0d faulting fetches returned.", hits_seen, faults_seen);
    if (errors == 0 && pending == 0)
      $display("tb_direct_mapped_instruction_fetch_top passed");
    else
      $display("tb_direct_mapped_instruction_fetch_top failed");
    $finish;
  end

endmodule

### sim.f
rtl/dmif_pkg.sv
rtl/dmif_ctrl.sv
rtl/dmif_datapath.sv
rtl/direct_mapped_instruction_fetch_top.sv
test/fetch_checker.sv
test/tb_direct_mapped_instruction_fetch_top.sv
